/* src/fp_to_int_saturating_convert_core_defines.svh */
// assertion macros for the float to integer converter
// used by the top level only
`ifndef FP_TO_INT_SATURATING_CONVERT_CORE_DEFINES_SVH
`define FP_TO_INT_SATURATING_CONVERT_CORE_DEFINES_SVH
`define FTI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define FTI_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* src/fti_pkg.sv */
// shared types and constants for the float to integer converter
// no dependencies
`default_nettype none
package fti_pkg;
  typedef enum logic [1:0] {
    OP_F_TO_I32 = 2'd0,
    OP_D_TO_I32 = 2'd1,
    OP_F_TO_I64 = 2'd2,
    OP_D_TO_I64 = 2'd3
  } fti_op_e;

  typedef struct packed {
    logic        neg;
    logic        is_nan;
    logic        sat;
    logic        zero;
    logic [63:0] mag;
  } fti_dec_t;
endpackage
`default_nettype wire

/* src/fp_to_int_saturating_convert_core.sv */
// top level of the saturating float to integer converter
// depends on fti_pkg, fti_decode, fti_result and the defines header
`default_nettype none
`include "fp_to_int_saturating_convert_core_defines.svh"
// One conversion per word: an input register feeds one combinational decode,
// shift and saturate stage, and a result register holds the answer. A word
// moves on from the input register to the result register, and a new word is
// taken every cycle while the output side accepts; the result register and
// input register then advance together, so throughput is one word per clock.
module fp_to_int_saturating_convert_core import fti_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [71:0] s_axis_tdata_i,  // op [1:0], operand_bits [65:2], zero [71:66]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o   // result [63:0]
);
  logic        in_vld_q, out_vld_q;
  logic [1:0]  op_q;
  logic [63:0] bits_q, res_q, res_d;
  logic        adv_out, adv_in;
  fti_dec_t    dec;

  assign adv_out         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv_out;
  assign adv_in          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_vld_q <= s_axis_tvalid_i;
      if (adv_out) out_vld_q <= 1'b1;
      else if (m_axis_tready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in) begin
      op_q   <= s_axis_tdata_i[1:0];
      bits_q <= s_axis_tdata_i[65:2];
    end
    if (adv_out) res_q <= res_d;
  end

  fti_decode u_dec (.op_i(op_q), .bits_i(bits_q), .dec_o(dec));
  fti_result u_res (.wide_i(op_q[1]), .dec_i(dec), .result_o(res_d));

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = res_q;

  `FTI_ASSERT(a_out_held, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o),
    "stalled result changed")
  `FTI_ASSERT(a_move, clk_i, rst_ni,
    adv_out |=> m_axis_tvalid_o, "result lost")
  `FTI_ASSERT(a_i32_ext, clk_i, rst_ni,
    in_vld_q && !op_q[1] |-> res_d[63:32] == {32{res_d[31]}}, "int32 not sign extended")
endmodule
`default_nettype wire

/* src/fti_decode.sv */
// decodes one float or double and shifts its significand to an integer magnitude
// depends on fti_pkg
`default_nettype none
module fti_decode import fti_pkg::*; (
  input  wire logic [1:0]  op_i,
  input  wire logic [63:0] bits_i,
  output fti_dec_t         dec_o
);
  logic        dbl, wide;
  logic [10:0] expf;
  logic [51:0] frac;
  logic [11:0] e;
  logic        exp_max, below;
  logic [63:0] sig;
  logic [6:0]  sh;

  always_comb begin
    dbl  = op_i[0];
    wide = op_i[1];
    if (dbl) begin
      dec_o.neg = bits_i[63];
      expf      = bits_i[62:52];
      frac      = bits_i[51:0];
      exp_max   = (expf == 11'h7ff);
      below     = (expf < 11'd1023);
      e         = {1'b0, expf} - 12'd1023;
    end else begin
      dec_o.neg = bits_i[31];
      expf      = {3'b000, bits_i[30:23]};
      frac      = {bits_i[22:0], 29'd0};
      exp_max   = (bits_i[30:23] == 8'hff);
      below     = (bits_i[30:23] < 8'd127);
      e         = {1'b0, expf} - 12'd127;
    end
    dec_o.is_nan = exp_max && (frac != 52'd0);
    dec_o.sat    = exp_max || (!below && (wide ? (e >= 12'd63) : (e >= 12'd31)));
    dec_o.zero   = below && !exp_max;
    // significand left aligned at bit 63, then shifted right by 63 - e
    sig = {1'b1, frac, 11'd0};
    sh  = 7'd63 - e[6:0];
    dec_o.mag = (dec_o.sat || dec_o.zero) ? 64'd0 : (sig >> sh);
  end
endmodule
`default_nettype wire

/* src/fti_result.sv */
// applies sign, nan, saturation and width limits to a decoded magnitude
// depends on fti_pkg
`default_nettype none
module fti_result import fti_pkg::*; (
  input  wire logic        wide_i,
  input  fti_dec_t         dec_i,
  output logic [63:0]      result_o
);
  always_comb begin
    if (dec_i.is_nan || dec_i.zero) begin
      result_o = 64'd0;
    end else if (dec_i.sat) begin
      if (wide_i) result_o = dec_i.neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      else        result_o = dec_i.neg ? 64'hffff_ffff_8000_0000 : 64'h0000_0000_7fff_ffff;
    end else begin
      result_o = dec_i.neg ? (64'd0 - dec_i.mag) : dec_i.mag;
    end
  end
endmodule
`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for the saturating float to integer converter
// drives op and bit pattern words, predicts each result and compares in order
// depends on fti_pkg and fp_to_int_saturating_convert_core
`default_nettype none
module tb;
  import fti_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    fti_op_e     op;
    logic [63:0] bits;
    logic        known;
    logic [63:0] res;
  } conv_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  logic [63:0] pending_results[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  conv_row_t   rows[$];

  fp_to_int_saturating_convert_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [63:0] truncate_saturate(fti_op_e op, logic [63:0] bits);
    logic        dbl;
    logic        wide;
    int          fbits;
    int          ebits;
    int          bias;
    int          dbits;
    logic [63:0] pat;
    logic        neg;
    logic [63:0] expf;
    logic [63:0] frac;
    logic [63:0] emask;
    logic [63:0] maxv;
    logic [63:0] minv;
    logic [63:0] sig;
    logic [63:0] mag;
    int          e;
    dbl = (op == OP_D_TO_I32) || (op == OP_D_TO_I64);
    wide = (op == OP_F_TO_I64) || (op == OP_D_TO_I64);
    fbits = dbl ? 52 : 23;
    ebits = dbl ? 11 : 8;
    bias = dbl ? 1023 : 127;
    dbits = wide ? 64 : 32;
    pat = dbl ? bits : {32'd0, bits[31:0]};
    neg = pat[fbits + ebits];
    emask = (64'd1 << ebits) - 1;
    expf = (pat >> fbits) & emask;
    frac = pat & ((64'd1 << fbits) - 1);
    maxv = (64'd1 << (dbits - 1)) - 1;
    minv = 64'd0 - (64'd1 << (dbits - 1));
    if (expf == emask) return (frac != 0) ? 64'd0 : (neg ? minv : maxv);
    if (expf < bias) return 64'd0;
    e = int'(expf) - bias;
    if (e >= dbits - 1) return neg ? minv : maxv;
    sig = frac | (64'd1 << fbits);
    mag = (e >= fbits) ? (sig << (e - fbits)) : (sig >> (fbits - e));
    return neg ? (64'd0 - mag) : mag;
  endfunction

  function automatic logic [63:0] random_pattern(fti_op_e op);
    logic [63:0] b;
    logic        dbl;
    int          ex;
    b = {$urandom, $urandom};
    dbl = (op == OP_D_TO_I32) || (op == OP_D_TO_I64);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if (dbl) begin
          ex = 1023 + $urandom_range(0, 70) - 4;
          b[62:52] = ex[10:0];
        end else begin
          ex = 127 + $urandom_range(0, 70) - 4;
          b[30:23] = ex[7:0];
        end
      end
      6: begin
        if (dbl) b[62:52] = '1;
        else b[30:23] = '1;
        if ($urandom_range(0, 1) == 0) begin
          if (dbl) b[51:0] = '0;
          else b[22:0] = '0;
        end
      end
      7: begin
        if (dbl) b[62:52] = '0;
        else b[30:23] = '0;
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic add_row(fti_op_e op, logic [63:0] bits, logic known = 0,
                         logic [63:0] res = '0);
    conv_row_t r;
    r.op = op;
    r.bits = bits;
    r.known = known;
    r.res = res;
    rows.push_back(r);
  endtask

  task automatic send_word(conv_row_t r);
    logic [63:0] exp_res;
    exp_res = truncate_saturate(r.op, r.bits);
    if (r.known && exp_res !== r.res) begin
      $display("%0t table entry disagrees: expected %h actual %h", $time, r.res, exp_res);
      errors++;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, r.bits, r.op};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pending_results.push_back(r.known ? r.res : exp_res);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
          errors++;
        end else begin
          if (m_tdata !== pending_results[0]) begin
            $display("%0t result mismatch: expected %h actual %h",
                     $time, pending_results[0], m_tdata);
            errors++;
          end
          void'(pending_results.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    fti_op_e op;
    conv_row_t r;
    int phase;
    add_row(OP_F_TO_I32, 64'h0, 1, 64'h0);
    add_row(OP_F_TO_I32, 64'h8000_0000, 1, 64'h0);
    add_row(OP_F_TO_I32, 64'hFFFF_FFFF_3F80_0000, 1, 64'h1);
    add_row(OP_F_TO_I32, 64'h7F80_0000, 1, 64'h0000_0000_7FFF_FFFF);
    add_row(OP_F_TO_I32, 64'hFF80_0000, 1, 64'hFFFF_FFFF_8000_0000);
    add_row(OP_F_TO_I32, 64'h7FC0_0001, 1, 64'h0);
    add_row(OP_F_TO_I32, 64'hCF00_0000, 1, 64'hFFFF_FFFF_8000_0000);
    add_row(OP_F_TO_I32, 64'h4EFF_FFFF);
    add_row(OP_F_TO_I32, 64'h007F_FFFF, 1, 64'h0);
    add_row(OP_F_TO_I32, 64'hBFC0_0000, 1, 64'hFFFF_FFFF_FFFF_FFFF);
    add_row(OP_D_TO_I32, 64'h7FF0_0000_0000_0000, 1, 64'h0000_0000_7FFF_FFFF);
    add_row(OP_D_TO_I32, 64'hFFF8_0000_0000_0000, 1, 64'h0);
    add_row(OP_D_TO_I32, 64'hC1E0_0000_0000_0000, 1, 64'hFFFF_FFFF_8000_0000);
    add_row(OP_D_TO_I32, 64'h41DF_FFFF_FFC0_0000, 1, 64'h0000_0000_7FFF_FFFF);
    add_row(OP_D_TO_I32, 64'h000F_FFFF_FFFF_FFFF, 1, 64'h0);
    add_row(OP_F_TO_I64, 64'h5F00_0000, 1, 64'h7FFF_FFFF_FFFF_FFFF);
    add_row(OP_F_TO_I64, 64'hDF00_0000, 1, 64'h8000_0000_0000_0000);
    add_row(OP_F_TO_I64, 64'h5EFF_FFFF);
    add_row(OP_F_TO_I64, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0);
    add_row(OP_D_TO_I64, 64'h43E0_0000_0000_0000, 1, 64'h7FFF_FFFF_FFFF_FFFF);
    add_row(OP_D_TO_I64, 64'hFFF0_0000_0000_0000, 1, 64'h8000_0000_0000_0000);
    add_row(OP_D_TO_I64, 64'h43DF_FFFF_FFFF_FFFF);
    add_row(OP_D_TO_I64, 64'hBFEF_FFFF_FFFF_FFFF, 1, 64'h0);
    add_row(OP_D_TO_I64, 64'h7FFF_FFFF_FFFF_FFFF, 1, 64'h0);
    add_row(OP_D_TO_I64, 64'h8000_0000_0000_0000, 1, 64'h0);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) send_word(rows[i]);
    s_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk_i);

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 78 : 0;
      recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 13 : 0;
      repeat (133) begin
        op = fti_op_e'($urandom_range(0, 3));
        r.op = op;
        r.bits = random_pattern(op);
        r.known = 1'b0;
        r.res = '0;
        send_word(r);
      end
    end
    s_tvalid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
